// ===== design/hlfp_pkg.sv =====
`timescale 1ns / 1ps

package hlfp_pkg;

  // Frame marker and command codes
  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam logic [7:0] CMD_SELECT = 8'h45;
  localparam logic [7:0] CMD_AREA   = 8'h15;

  // Smallest legal frame: header, command and length field
  localparam logic [15:0] MIN_FRAME     = 16'd5;
  localparam logic [7:0]  SECTION_LIMIT = 8'd5;

  // Byte positions inside a frame
  localparam int unsigned POS_SYNC0   = 0;
  localparam int unsigned POS_SYNC1   = 1;
  localparam int unsigned POS_CMD     = 2;
  localparam int unsigned POS_LEN_HI  = 3;
  localparam int unsigned POS_LEN_LO  = 4;
  localparam int unsigned POS_PAYLOAD = 5;

  // One completed frame
  typedef struct packed {
    logic [7:0] command_code;
    logic [8:0] frame_length;
    logic       section_valid;
    logic [2:0] section_number;
    logic       area_ready;
  } result_t;

endpackage

// ===== design/header_length_frame_parser.sv =====
`timescale 1ns / 1ps

// Frame parser for a received byte stream.
// Input channel: one byte per request on rx_byte_i, accepted when in_valid_i
// is high and in_stall_o is low. Frames are 0x5A 0x5A, a command byte, a
// big-endian 16-bit total length (header included), then payload.
// Output channel: one request per completed frame on the *_o result ports,
// taken when out_valid_o is high and out_stall_i is low. Bad headers and
// lengths outside 5..MAX_FRAME_LEN drop the frame silently.
// The result of a frame appears in the cycle after its last byte is
// accepted. Throughput: one byte per cycle while in_stall_o is low; the next
// byte count, the length compare and the result are all formed combinationally.
// The result register decouples the two sides: a new byte is taken while a
// finished result waits, unless the result register is full and the
// receiver stalls, in which case in_stall_o is raised until it drains.
// Reset (rst_ni low, asynchronous) clears the frame counter, the area-ready
// flag and the output valid; the parser then waits for a fresh header.
module header_length_frame_parser
  import hlfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] command_code_o,
  output logic [8:0] frame_length_o,
  output logic       section_valid_o,
  output logic [2:0] section_number_o,
  output logic       area_ready_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME_LEN);

  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       command_q, command_d;
  logic [7:0]       len_high_q, len_high_d;
  logic [CNT_W-1:0] frame_len_q, frame_len_d;
  logic [7:0]       first_payload_q, first_payload_d;
  logic             area_q, area_d;
  logic             out_valid_q;
  result_t          result_q, result_d;
  logic             finish;
  logic             accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Advance the frame state for one byte and build the result on the last byte
  always_comb begin
    logic [15:0] len_word;
    logic [CNT_W-1:0] count_inc;
    logic [7:0] payload_byte;
    logic [15:0] len_ext;
    count_d         = count_q;
    command_d       = command_q;
    len_high_d      = len_high_q;
    frame_len_d     = frame_len_q;
    first_payload_d = first_payload_q;
    area_d          = area_q;
    finish          = 1'b0;
    len_word        = {len_high_q, rx_byte_i};
    count_inc       = count_q + CNT_W'(1);
    payload_byte    = first_payload_q;
    unique case (count_q)
      CNT_W'(POS_SYNC0): begin
        count_d = (rx_byte_i == SYNC_BYTE) ? CNT_W'(POS_SYNC1) : CNT_W'(POS_SYNC0);
      end
      CNT_W'(POS_SYNC1): begin
        count_d = (rx_byte_i == SYNC_BYTE) ? CNT_W'(POS_CMD) : CNT_W'(POS_SYNC0);
      end
      CNT_W'(POS_CMD): begin
        command_d = rx_byte_i;
        count_d   = CNT_W'(POS_LEN_HI);
      end
      CNT_W'(POS_LEN_HI): begin
        len_high_d = rx_byte_i;
        count_d    = CNT_W'(POS_LEN_LO);
      end
      CNT_W'(POS_LEN_LO): begin
        // Drop frames whose length is out of range
        if (len_word > LEN_LIMIT || len_word < MIN_FRAME) begin
          count_d = CNT_W'(POS_SYNC0);
        end else begin
          frame_len_d = CNT_W'(len_word);
          count_d     = CNT_W'(POS_PAYLOAD);
          finish      = (len_word == MIN_FRAME);
        end
      end
      default: begin
        if (count_q == CNT_W'(POS_PAYLOAD)) begin
          first_payload_d = rx_byte_i;
          payload_byte    = rx_byte_i;
        end
        count_d = count_inc;
        finish  = (count_inc >= frame_len_q);
      end
    endcase

    len_ext                 = 16'(frame_len_d);
    result_d.command_code   = command_d;
    result_d.frame_length   = len_ext[8:0];
    result_d.section_valid  = 1'b0;
    result_d.section_number = 3'd0;
    if (finish) begin
      count_d = CNT_W'(POS_SYNC0);
      if (command_d == CMD_SELECT) begin
        if (len_ext > MIN_FRAME && payload_byte < SECTION_LIMIT) begin
          result_d.section_valid  = 1'b1;
          result_d.section_number = payload_byte[2:0] + 3'd1;
        end
        area_d = 1'b0;
      end else if (command_d == CMD_AREA) begin
        area_d = 1'b1;
      end
    end
    result_d.area_ready = area_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      area_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        area_q  <= area_d;
      end
      if (accept && finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame fields and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      command_q       <= command_d;
      len_high_q      <= len_high_d;
      frame_len_q     <= frame_len_d;
      first_payload_q <= first_payload_d;
    end
    if (accept && finish) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_code_o   = result_q.command_code;
  assign frame_length_o   = result_q.frame_length;
  assign section_valid_o  = result_q.section_valid;
  assign section_number_o = result_q.section_number;
  assign area_ready_o     = result_q.area_ready;

`ifndef SYNTHESIS
  a_section_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && section_valid_o |-> command_code_o == CMD_SELECT &&
      section_number_o != 3'd0)
    else $error("section reported for a non-select frame");

  a_area_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_code_o == CMD_AREA |-> area_ready_o)
    else $error("area command did not set the flag");

  a_area_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_code_o == CMD_SELECT |-> !area_ready_o)
    else $error("select command did not clear the flag");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_FRAME_LEN)
    else $error("byte counter beyond the frame limit");

  a_bad_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && count_q == CNT_W'(POS_SYNC0) && rx_byte_i != SYNC_BYTE |=>
      count_q == CNT_W'(POS_SYNC0))
    else $error("counter left idle on a non-header byte");
`endif

endmodule
